/* design/object_age_census_tenuring_core_assert.svh */
// Assertion helpers shared by the census core.
`ifndef OBJECT_AGE_CENSUS_TENURING_CORE_ASSERT_SVH
`define OBJECT_AGE_CENSUS_TENURING_CORE_ASSERT_SVH

// Holds in the same cycle as the trigger.
`define OACT_ASSERT_NOW(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) \
    else $error(msg);

// Holds in the cycle after the trigger.
`define OACT_ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
    else $error(msg);

// Holds later than the trigger: a non-overlapping implication followed by a further delay.
`define OACT_ASSERT_LATER(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> ##1 (cons)) \
    else $error(msg);

`endif

/* design/oact_pkg.sv */
package oact_pkg;

  localparam int COHORTS     = 16;
  localparam int SNAPSHOTS   = 16;
  localparam int COUNT_W     = 48;
  localparam int COH_W       = $clog2(COHORTS);
  localparam int SNAP_W      = $clog2(SNAPSHOTS);
  localparam int SNAP_ADDR_W = SNAP_W + COH_W;
  localparam int THR_W       = 5;
  localparam int AGE_W       = 5;
  localparam int RAGE_W      = 4;
  localparam int SIZE_W      = 32;
  localparam int POP_W       = 32;
  localparam int MORT_W      = 17;
  localparam int PROD_W      = COUNT_W + MORT_W;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [AGE_W-1:0] MAX_OBJ_AGE = AGE_W'(15);
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Operation codes.
  localparam logic [1:0] OP_ADD        = 2'd0;
  localparam logic [1:0] OP_ADVANCE    = 2'd1;
  localparam logic [1:0] OP_CLEAR_HIST = 2'd2;
  localparam logic [1:0] OP_READ       = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ADAPTIVE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_THR    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_THR     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_THR     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_POP_LIMIT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MORT_LIMIT  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_RGN_AGE     = 3'd6;

  // Reset values of the configuration registers.
  localparam logic              RST_ADAPTIVE   = 1'b1;
  localparam logic [THR_W-1:0]  RST_INIT_THR   = THR_W'(7);
  localparam logic [THR_W-1:0]  RST_MIN_THR    = THR_W'(1);
  localparam logic [THR_W-1:0]  RST_MAX_THR    = THR_W'(16);
  localparam logic [POP_W-1:0]  RST_POP_LIMIT  = POP_W'(4096);
  localparam logic [MORT_W-1:0] RST_MORT_LIMIT = MORT_W'(6554);
  localparam logic              RST_RGN_AGE    = 1'b1;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [AGE_W-1:0]  object_age;
    logic [RAGE_W-1:0] rgn_age;
    logic [SIZE_W-1:0] object_size;
  } cmd_t;

  typedef struct packed {
    logic [THR_W-1:0]  threshold;
    logic [SNAP_W-1:0] epoch_index;
  } rsp_t;

endpackage

/* design/oact_ram.sv */
module oact_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/object_age_census_tenuring_core.sv */
// Channel   Handshake              Payload
// --------  ---------------------  ----------------------------------------
// command   start / busy           opcode, object_age, rgn_age, size
// result    done (one-cycle)       threshold, epoch_index
// config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// An add does one histogram memory read, then the saturating write back.
// Read and history clear finish without leaving idle. An advance copies the
// live histogram into a snapshot and then, if adaptive, scans at most
// COHORTS-1 cohorts: the copy walks the live histogram one cohort
// a cycle, and each scan step reads two snapshot counts through the single
// read port and multiplies once. Reset is synchronous;
// memory contents are masked by valid bits, so there is no clearing pass.
// done lasts one cycle and cannot be held off; cfg_ready is always high.
`include "object_age_census_tenuring_core_assert.svh"

module object_age_census_tenuring_core
  import oact_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  cmd_t                  command,
  output logic                  done,
  output rsp_t                  result,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_ADD      = 4'd1;
  localparam logic [3:0] S_COPY     = 4'd2;
  localparam logic [3:0] S_COPY_END = 4'd3;
  localparam logic [3:0] S_PREV     = 4'd4;
  localparam logic [3:0] S_CUR      = 4'd5;
  localparam logic [3:0] S_MUL      = 4'd6;
  localparam logic [3:0] S_DEC      = 4'd7;
  localparam logic [3:0] S_WRTH     = 4'd8;

  // Configuration.
  logic              adaptive_enable;
  logic [THR_W-1:0]  initial_threshold;
  logic [THR_W-1:0]  min_threshold;
  logic [THR_W-1:0]  max_threshold;
  logic [POP_W-1:0]  population_limit;
  logic [MORT_W-1:0] mortality_limit;
  logic              add_rgn_age;

  logic [3:0]         state;
  logic [SNAP_W-1:0]  epoch;
  logic [COHORTS-1:0] live_valid;
  logic [SNAPSHOTS-1:0] slot_valid;
  logic [THR_W-1:0]   thr_mem [SNAPSHOTS];

  logic [COH_W-1:0]   add_age;
  logic [SIZE_W-1:0]  add_size;
  logic               add_skip;
  logic [COH_W-1:0]   copy_cnt;
  logic               copy_wr;
  logic               copy_lv;
  logic [COH_W-1:0]   copy_idx;
  logic [COH_W-1:0]   scan_i;
  logic [THR_W-1:0]   tt;
  logic [COUNT_W-1:0] prev_q;
  logic [COUNT_W-1:0] diff_q;
  logic               le_q;
  logic [PROD_W-1:0]  prod_q;

  logic               live_we;
  logic [COH_W-1:0]   live_waddr;
  logic [COUNT_W-1:0] live_wdata;
  logic [COH_W-1:0]   live_raddr;
  logic [COUNT_W-1:0] live_rdata;
  logic               snap_we;
  logic [SNAP_ADDR_W-1:0] snap_waddr;
  logic [COUNT_W-1:0] snap_wdata;
  logic [SNAP_ADDR_W-1:0] snap_raddr;
  logic [COUNT_W-1:0] snap_rdata;

  logic               accept;
  logic               done_next;
  logic [AGE_W:0]     age_sum;
  logic [COH_W-1:0]   age_idx;
  logic [COUNT_W:0]   add_sum;
  logic [COUNT_W-1:0] add_old;
  logic [SNAP_W-1:0]  epoch_inc;
  logic [SNAP_W-1:0]  prev_slot;
  logic [THR_W-1:0]   scan_hi;
  logic [THR_W-1:0]   scan_lo;
  logic [COH_W-1:0]   scan_start;
  logic [THR_W-1:0]   fixed_thr;
  logic               below_pop;
  logic               mort_below;
  logic               keep_going;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // The result strobe follows the last busy cycle, or the accept of a read or history clear.
  assign done_next = (state == S_ADD) || (state == S_WRTH)
                  || (accept && (command.opcode == OP_CLEAR_HIST || command.opcode == OP_READ));

  // Cohort of a new sample: object age plus optional region age, clamped.
  always_comb begin
    age_sum = {1'b0, command.object_age}
            + (add_rgn_age ? (AGE_W+1)'(command.rgn_age) : '0);
    if (age_sum > (AGE_W+1)'(COHORTS - 1)) begin
      age_idx = COH_W'(COHORTS - 1);
    end else begin
      age_idx = age_sum[COH_W-1:0];
    end
  end

  assign epoch_inc = (epoch == SNAP_W'(SNAPSHOTS - 1)) ? '0 : epoch + 1'b1;
  assign prev_slot = (epoch == '0) ? SNAP_W'(SNAPSHOTS - 1) : epoch - 1'b1;

  always_comb begin
    if (max_threshold == '0) begin
      scan_hi = THR_W'(1);
    end else if (max_threshold > THR_W'(COHORTS)) begin
      scan_hi = THR_W'(COHORTS);
    end else begin
      scan_hi = max_threshold;
    end
    if (min_threshold <= THR_W'(2)) begin
      scan_lo = THR_W'(1);
    end else begin
      scan_lo = min_threshold - 1'b1;
    end
    if (initial_threshold > THR_W'(COHORTS)) begin
      fixed_thr = THR_W'(COHORTS);
    end else begin
      fixed_thr = initial_threshold;
    end
  end

  assign scan_start = COH_W'(scan_hi - 1'b1);

  // Saturating add of the sample size to the live count.
  assign add_old = live_valid[add_age] ? live_rdata : '0;
  assign add_sum = {1'b0, add_old} + (COUNT_W+1)'(add_size);

  // Scan decision on the registered previous count, difference and product.
  assign below_pop  = prev_q < COUNT_W'(population_limit);
  assign mort_below = le_q ? (mortality_limit != '0)
                           : ({1'b0, diff_q, 16'b0} < prod_q);
  assign keep_going = (scan_i > COH_W'(1)) && (below_pop || mort_below);

  // Live histogram ports.
  assign live_we    = (state == S_ADD) && !add_skip;
  assign live_waddr = add_age;
  assign live_wdata = add_sum[COUNT_W] ? COUNT_MAX : add_sum[COUNT_W-1:0];
  assign live_raddr = (state == S_COPY) ? copy_cnt : age_idx;

  // Snapshot histogram ports.
  assign snap_we    = copy_wr;
  assign snap_waddr = {epoch, copy_idx};
  assign snap_wdata = copy_lv ? live_rdata : '0;
  assign snap_raddr = (state == S_CUR) ? {epoch, scan_i}
                                       : {prev_slot, scan_i - 1'b1};

  oact_ram #(.WIDTH(COUNT_W), .DEPTH(COHORTS)) u_live_ram (
    .clk   (clk),
    .we    (live_we),
    .waddr (live_waddr),
    .wdata (live_wdata),
    .raddr (live_raddr),
    .rdata (live_rdata)
  );

  oact_ram #(.WIDTH(COUNT_W), .DEPTH(SNAPSHOTS * COHORTS)) u_snap_ram (
    .clk   (clk),
    .we    (snap_we),
    .waddr (snap_waddr),
    .wdata (snap_wdata),
    .raddr (snap_raddr),
    .rdata (snap_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      adaptive_enable   <= RST_ADAPTIVE;
      initial_threshold <= RST_INIT_THR;
      min_threshold     <= RST_MIN_THR;
      max_threshold     <= RST_MAX_THR;
      population_limit  <= RST_POP_LIMIT;
      mortality_limit   <= RST_MORT_LIMIT;
      add_rgn_age       <= RST_RGN_AGE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ADAPTIVE:   adaptive_enable   <= cfg_data[0];
        CFG_INIT_THR:   initial_threshold <= cfg_data[THR_W-1:0];
        CFG_MIN_THR:    min_threshold     <= cfg_data[THR_W-1:0];
        CFG_MAX_THR:    max_threshold     <= cfg_data[THR_W-1:0];
        CFG_POP_LIMIT:  population_limit  <= cfg_data[POP_W-1:0];
        CFG_MORT_LIMIT: mortality_limit   <= cfg_data[MORT_W-1:0];
        CFG_RGN_AGE:    add_rgn_age       <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk) begin
    copy_lv  <= live_valid[copy_cnt];
    copy_idx <= copy_cnt;
    if (accept) begin
      add_age  <= age_idx;
      add_size <= command.object_size;
      add_skip <= (command.object_age > MAX_OBJ_AGE);
    end
    if (state == S_CUR) begin
      prev_q <= slot_valid[prev_slot] ? snap_rdata : '0;
    end
    if (state == S_MUL) begin
      le_q   <= (prev_q <= snap_rdata);
      diff_q <= prev_q - snap_rdata;
      prod_q <= {{MORT_W{1'b0}}, prev_q} * {{COUNT_W{1'b0}}, mortality_limit};
    end
    if (accept && command.opcode == OP_CLEAR_HIST) begin
      result.threshold   <= thr_mem[SNAPSHOTS-1];
      result.epoch_index <= SNAP_W'(SNAPSHOTS - 1);
    end else if (state == S_WRTH) begin
      result.threshold   <= tt;
      result.epoch_index <= epoch;
    end else begin
      result.threshold   <= thr_mem[epoch];
      result.epoch_index <= epoch;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      epoch      <= SNAP_W'(SNAPSHOTS - 1);
      live_valid <= '0;
      slot_valid <= '0;
      done       <= 1'b0;
      copy_wr    <= 1'b0;
      copy_cnt   <= '0;
      scan_i     <= '0;
      tt         <= '0;
      for (int k = 0; k < SNAPSHOTS; k++) begin
        thr_mem[k] <= THR_W'(COHORTS);
      end
    end else begin
      done    <= done_next;
      copy_wr <= (state == S_COPY);
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (command.opcode)
              OP_ADD: begin
                state <= S_ADD;
              end
              OP_ADVANCE: begin
                epoch    <= epoch_inc;
                copy_cnt <= '0;
                state    <= S_COPY;
              end
              OP_CLEAR_HIST: begin
                slot_valid <= '0;
                epoch      <= SNAP_W'(SNAPSHOTS - 1);
              end
              default: ;
            endcase
          end
        end
        S_ADD: begin
          if (!add_skip) begin
            live_valid[add_age] <= 1'b1;
          end
          state <= S_IDLE;
        end
        S_COPY: begin
          copy_cnt <= copy_cnt + 1'b1;
          if (copy_cnt == COH_W'(COHORTS - 1)) begin
            state <= S_COPY_END;
          end
        end
        S_COPY_END: begin
          // The last cohort lands in the snapshot memory at this edge.
          live_valid        <= '0;
          slot_valid[epoch] <= 1'b1;
          if (adaptive_enable) begin
            tt     <= scan_hi;
            scan_i <= scan_start;
            if (THR_W'(scan_start) >= scan_lo) begin
              state <= S_PREV;
            end else begin
              state <= S_WRTH;
            end
          end else begin
            tt    <= fixed_thr;
            state <= S_WRTH;
          end
        end
        S_PREV: state <= S_CUR;
        S_CUR:  state <= S_MUL;
        S_MUL:  state <= S_DEC;
        S_DEC: begin
          if (keep_going) begin
            tt <= THR_W'(scan_i);
            if (THR_W'(scan_i) > scan_lo) begin
              scan_i <= scan_i - 1'b1;
              state  <= S_PREV;
            end else begin
              state <= S_WRTH;
            end
          end else begin
            state <= S_WRTH;
          end
        end
        S_WRTH: begin
          thr_mem[epoch] <= tt;
          state          <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `OACT_ASSERT_NOW(a_done_idle, done, !busy, "result strobe while an item is in flight")
  `OACT_ASSERT_LATER(a_add_two, accept && command.opcode == OP_ADD, done,
                     "add sample did not finish in two cycles")
  `OACT_ASSERT_NEXT(a_quick_ops,
                    accept && (command.opcode == OP_READ || command.opcode == OP_CLEAR_HIST),
                    done && !busy, "read or clear did not finish in one cycle")
  `OACT_ASSERT_NOW(a_scan_floor, state == S_PREV, THR_W'(scan_i) >= scan_lo,
                   "adaptive scan went below its floor")
  `OACT_ASSERT_NOW(a_thr_range, done, result.threshold <= THR_W'(COHORTS),
                   "threshold above cohort count")

endmodule

/* sim/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import oact_pkg::*;

  // Index past the last register; writes to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  cmd_t                  command = '0;
  logic                  done;
  rsp_t                  result;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  object_age_census_tenuring_core dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .command   (command),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  cmd_t cmd_backlog[$];
  rsp_t expected_census[$];
  int   idle_pct = 31;
  bit   drain_hold = 1'b0;
  bit   cmd_taken = 1'b0;
  int   mismatches = 0;

  // Census state as the block should hold it.
  logic [COUNT_W-1:0] live_hist [COHORTS];
  logic [COUNT_W-1:0] snap_hist [SNAPSHOTS][COHORTS];
  logic [THR_W-1:0]   snap_thr [SNAPSHOTS];
  logic [SNAP_W-1:0]  model_epoch;

  logic               use_adaptive   = RST_ADAPTIVE;
  logic [THR_W-1:0]   fixed_thr      = RST_INIT_THR;
  logic [THR_W-1:0]   floor_thr      = RST_MIN_THR;
  logic [THR_W-1:0]   ceil_thr       = RST_MAX_THR;
  logic [POP_W-1:0]   pop_limit      = RST_POP_LIMIT;
  logic [MORT_W-1:0]  mort_limit     = RST_MORT_LIMIT;
  logic               use_rgn_age    = RST_RGN_AGE;

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic rsp_t census_step(input cmd_t c);
    rsp_t                r;
    int                  age;
    int                  k;
    int                  e;
    int                  hi;
    int                  lo;
    bit                  going;
    bit                  low_mort;
    logic [COUNT_W:0]    sum;
    logic [COUNT_W-1:0]  prev;
    logic [COUNT_W-1:0]  cur;
    logic [SNAP_W-1:0]   prev_slot;
    logic [THR_W-1:0]    thr;
    case (c.opcode)
      OP_ADD: begin
        if (c.object_age <= MAX_OBJ_AGE) begin
          age = int'(c.object_age) + (use_rgn_age ? int'(c.rgn_age) : 0);
          if (age > COHORTS - 1) age = COHORTS - 1;
          sum = {1'b0, live_hist[age]} + (COUNT_W+1)'(c.object_size);
          if (sum > COUNT_MAX) sum = COUNT_MAX;
          live_hist[age] = sum[COUNT_W-1:0];
        end
      end
      OP_ADVANCE: begin
        model_epoch = (model_epoch == SNAP_W'(SNAPSHOTS - 1)) ? '0 : model_epoch + 1'b1;
        for (k = 0; k < COHORTS; k++) begin
          snap_hist[model_epoch][k] = live_hist[k];
          live_hist[k] = '0;
        end
        if (use_adaptive) begin
          prev_slot = model_epoch - 1'b1;
          hi = int'(ceil_thr);
          if (hi < 1) hi = 1;
          if (hi > COHORTS) hi = COHORTS;
          lo = int'(floor_thr) - 1;
          if (lo < 1) lo = 1;
          thr = THR_W'(hi);
          going = 1'b1;
          // Walk down from the top cohort while each one is small or barely dying.
          for (k = hi - 1; k >= lo && going; k--) begin
            prev = snap_hist[prev_slot][k-1];
            cur = snap_hist[model_epoch][k];
            if (prev <= cur) begin
              low_mort = (mort_limit != 0);
            end else begin
              low_mort = {2'b00, prev - cur, 16'h0000} < {18'd0, prev} * {49'd0, mort_limit};
            end
            if (k > 1 && (prev < pop_limit || low_mort)) begin
              thr = THR_W'(k);
            end else begin
              going = 1'b0;
            end
          end
          snap_thr[model_epoch] = thr;
        end else begin
          snap_thr[model_epoch] = (fixed_thr > COHORTS) ? THR_W'(COHORTS) : fixed_thr;
        end
      end
      OP_CLEAR_HIST: begin
        for (e = 0; e < SNAPSHOTS; e++) begin
          for (k = 0; k < COHORTS; k++) snap_hist[e][k] = '0;
        end
        model_epoch = SNAP_W'(SNAPSHOTS - 1);
      end
      default: ;
    endcase
    r.threshold = snap_thr[model_epoch];
    r.epoch_index = model_epoch;
    return r;
  endfunction

  // Checks result beats, records accepted commands and register writes.
  always @(posedge clk) begin
    rsp_t want;
    cmd_taken = 1'b0;
    if (!rst) begin
      if (done) begin
        if (expected_census.size() == 0) begin
          if (mismatches < 10) begin
            $display("%0t: result with nothing pending: threshold=%0d epoch=%0d",
                     $realtime, result.threshold, result.epoch_index);
          end
          mismatches++;
        end else begin
          want = expected_census.pop_front();
          if (result.threshold !== want.threshold || result.epoch_index !== want.epoch_index) begin
            if (mismatches < 10) begin
              $display("%0t: mismatch: threshold exp %0d got %0d, epoch exp %0d got %0d",
                       $realtime, want.threshold, result.threshold,
                       want.epoch_index, result.epoch_index);
            end
            mismatches++;
          end
        end
      end
      if (start && !busy) begin
        cmd_taken = 1'b1;
        expected_census.push_back(census_step(command));
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ADAPTIVE:   use_adaptive = cfg_data[0];
          CFG_INIT_THR:   fixed_thr = cfg_data[THR_W-1:0];
          CFG_MIN_THR:    floor_thr = cfg_data[THR_W-1:0];
          CFG_MAX_THR:    ceil_thr = cfg_data[THR_W-1:0];
          CFG_POP_LIMIT:  pop_limit = cfg_data[POP_W-1:0];
          CFG_MORT_LIMIT: mort_limit = cfg_data[MORT_W-1:0];
          CFG_RGN_AGE:    use_rgn_age = cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  // Command driver; now and then it holds off until every result is back.
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || cmd_taken) begin
      if (drain_hold && expected_census.size() == 0) drain_hold = 1'b0;
      if (cmd_backlog.size() != 0 && !drain_hold && $urandom_range(99) >= idle_pct) begin
        command <= cmd_backlog.pop_front();
        start <= 1'b1;
        drain_hold = ($urandom_range(79) == 0);
      end else begin
        start <= 1'b0;
      end
    end
  end

  task automatic add_cmd(input logic [1:0] op, input logic [AGE_W-1:0] age,
                         input logic [RAGE_W-1:0] rage, input logic [SIZE_W-1:0] words);
    cmd_t c;
    c.opcode = op;
    c.object_age = age;
    c.rgn_age = rage;
    c.object_size = words;
    cmd_backlog.push_back(c);
  endtask

  task automatic wait_idle();
    while (cmd_backlog.size() != 0 || expected_census.size() != 0 || start) @(posedge clk);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic reconfigure(input logic adaptive, input logic [THR_W-1:0] init_thr,
                             input logic [THR_W-1:0] min_thr, input logic [THR_W-1:0] max_thr,
                             input logic [POP_W-1:0] pop, input logic [MORT_W-1:0] mort,
                             input logic region);
    wait_idle();
    set_reg(CFG_ADAPTIVE, CFG_DATA_W'(adaptive));
    set_reg(CFG_INIT_THR, CFG_DATA_W'(init_thr));
    set_reg(CFG_MIN_THR, CFG_DATA_W'(min_thr));
    set_reg(CFG_MAX_THR, CFG_DATA_W'(max_thr));
    set_reg(CFG_POP_LIMIT, CFG_DATA_W'(pop));
    set_reg(CFG_MORT_LIMIT, CFG_DATA_W'(mort));
    set_reg(CFG_RGN_AGE, CFG_DATA_W'(region));
    set_reg(CFG_SPARE, $urandom);
    @(negedge clk) cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Epochs of adds that roughly follow the previous population, then an advance,
  // with stray commands of any kind mixed in.
  task automatic queue_random(input int count);
    int          k;
    int          a;
    logic [31:0] base;
    logic [31:0] spread;
    logic [31:0] sz;
    k = 0;
    base = $urandom_range(4500);
    while (k < count) begin
      if ($urandom_range(1) == 0) begin
        case ($urandom_range(3))
          0: base = $urandom_range(4500);
          1: base = $urandom_range(300000, 2000);
          2: base = $urandom;
          default: base = 32'hFFFF_FFFF - $urandom_range(255);
        endcase
      end
      for (a = 0; a < COHORTS; a++) begin
        if ($urandom_range(3) != 0) begin
          spread = base >> $urandom_range(7, 1);
          if ($urandom_range(1) == 0) begin
            sz = base - $urandom_range(spread, 0);
          end else if (base > ~spread) begin
            sz = '1;
          end else begin
            sz = base + $urandom_range(spread, 0);
          end
          add_cmd(OP_ADD, 5'(a), ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'd0, sz);
          k++;
        end
        if ($urandom_range(11) == 0) begin
          add_cmd(2'($urandom), 5'($urandom), 4'($urandom), $urandom);
          k++;
        end
      end
      add_cmd(OP_ADVANCE, 5'($urandom), 4'($urandom), $urandom);
      k++;
      if ($urandom_range(7) == 0) begin
        add_cmd(OP_READ, 5'($urandom), 4'($urandom), $urandom);
        k++;
      end
      if ($urandom_range(29) == 0) begin
        add_cmd(OP_CLEAR_HIST, 5'($urandom), 4'($urandom), $urandom);
        k++;
      end
    end
  endtask

  initial begin
    int e;
    int k;
    for (e = 0; e < SNAPSHOTS; e++) begin
      snap_thr[e] = THR_W'(COHORTS);
      for (k = 0; k < COHORTS; k++) snap_hist[e][k] = '0;
    end
    for (k = 0; k < COHORTS; k++) live_hist[k] = '0;
    model_epoch = SNAP_W'(SNAPSHOTS - 1);

    repeat (5) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Directed commands under the reset settings.
    add_cmd(OP_READ, 5'd0, 4'd0, 32'd0);
    add_cmd(OP_ADD, 5'd0, 4'd0, 32'd0);
    add_cmd(OP_ADD, 5'd15, 4'd15, 32'hFFFF_FFFF);
    add_cmd(OP_ADD, 5'd31, 4'd15, 32'hFFFF_FFFF);
    add_cmd(OP_ADD, 5'd16, 4'd0, 32'd5);
    add_cmd(OP_ADD, 5'd1, 4'd0, 32'd3000);
    add_cmd(OP_ADD, 5'd2, 4'd0, 32'd5000);
    add_cmd(OP_ADD, 5'd3, 4'd9, 32'd100);
    add_cmd(OP_ADVANCE, 5'd31, 4'd15, 32'hFFFF_FFFF);
    add_cmd(OP_ADD, 5'd2, 4'd0, 32'd2900);
    add_cmd(OP_ADD, 5'd3, 4'd0, 32'd4800);
    add_cmd(OP_ADD, 5'd4, 4'd0, 32'd100);
    add_cmd(OP_ADD, 5'd1, 4'd0, 32'd100000);
    add_cmd(OP_ADVANCE, 5'd0, 4'd0, 32'd0);
    add_cmd(OP_READ, 5'd31, 4'd15, 32'hFFFF_FFFF);
    add_cmd(OP_CLEAR_HIST, 5'd7, 4'd3, 32'h1234_5678);
    add_cmd(OP_READ, 5'd0, 4'd0, 32'd0);
    add_cmd(OP_ADVANCE, 5'd0, 4'd0, 32'd0);
    queue_random(120);

    // Fixed threshold at both ends, first without region age and then with it.
    reconfigure(1'b0, 5'd31, 5'd1, 5'd16, 32'd4096, 17'd6554, 1'b0);
    add_cmd(OP_ADVANCE, 5'd0, 4'd0, 32'd0);
    queue_random(120);
    reconfigure(1'b0, 5'd0, 5'd1, 5'd16, 32'd4096, 17'd6554, 1'b1);
    add_cmd(OP_ADVANCE, 5'd0, 4'd0, 32'd0);
    queue_random(120);

    // Zero min, oversized max, zero population limit, mortality limit above one.
    reconfigure(1'b1, 5'd16, 5'd0, 5'd31, 32'd0, 17'h1FFFF, 1'b1);
    add_cmd(OP_ADVANCE, 5'd0, 4'd0, 32'd0);
    queue_random(120);

    idle_pct = 71;
    // Scan floor above its start.
    reconfigure(1'b1, 5'd7, 5'd16, 5'd1, 32'hFFFF_FFFF, 17'd0, 1'b1);
    add_cmd(OP_ADVANCE, 5'd0, 4'd0, 32'd0);
    queue_random(120);
    reconfigure(1'b1, 5'd7, 5'd2, 5'd16, 32'd4096, 17'd65536, 1'b0);
    queue_random(120);
    reconfigure(1'b1, 5'($urandom_range(16)), 5'($urandom_range(16, 1)),
                5'($urandom_range(16, 1)), $urandom_range(20000), 17'($urandom_range(65536)),
                1'($urandom));
    queue_random(120);

    idle_pct = 0;
    reconfigure(1'b1, 5'd7, 5'd1, 5'd16, 32'd4096, 17'd6554, 1'b0);
    queue_random(120);
    reconfigure(1'b1, 5'd16, 5'd3, 5'd9, $urandom, 17'd30000, 1'b1);
    queue_random(120);

    // Pile the top cohort high, then run two advances over it.
    reconfigure(1'b1, 5'd7, 5'd1, 5'd16, 32'd4096, 17'd6554, 1'b1);
    for (k = 0; k < 40; k++) add_cmd(OP_ADD, 5'd15, 4'($urandom), 32'hFFFF_FFFF);
    add_cmd(OP_ADD, 5'd14, 4'd0, 32'd5);
    add_cmd(OP_ADVANCE, 5'd0, 4'd0, 32'd0);
    add_cmd(OP_ADD, 5'd15, 4'd0, 32'd77);
    add_cmd(OP_ADVANCE, 5'd0, 4'd0, 32'd0);
    add_cmd(OP_READ, 5'd0, 4'd0, 32'd0);

    wait_idle();
    repeat (100) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule
